### rtl/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants of the life grid generation step core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

   // grid geometry
   localparam int GRID_ROWS      = 8;
   localparam int GRID_COLS      = 8;
   localparam int MAX_SHOWN_ROWS = 8;
   localparam int MASK_BITS      = 8;

   localparam int SHOWN_ROWS = (GRID_ROWS < MAX_SHOWN_ROWS) ? GRID_ROWS : MAX_SHOWN_ROWS;
   localparam int ROW_W      = $clog2(GRID_ROWS);

   // fixed field widths
   localparam int OP_W    = 2;
   localparam int IDX_W   = 3;
   localparam int MASK_W  = 8;
   localparam int NBR_W   = 4;

   // neighbor counts of the rule
   localparam logic [NBR_W-1:0] NBR_BIRTH = NBR_W'(3);
   localparam logic [NBR_W-1:0] NBR_KEEP  = NBR_W'(2);

   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_LOAD    = 2'd0;
   localparam op_type OP_ADVANCE = 2'd1;
   localparam op_type OP_SHOW    = 2'd2;

   typedef logic [1:0] cell_type;
   localparam cell_type CELL_DEAD    = 2'd0;
   localparam cell_type CELL_NEWBORN = 2'd1;
   localparam cell_type CELL_SURV2   = 2'd2;
   localparam cell_type CELL_SURV3   = 2'd3;

   typedef cell_type [GRID_COLS-1:0] row_type;

   typedef enum logic {
      ST_IDLE,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      logic             load_en;
      logic             sweep;
      logic             advance;
      logic             first;
      logic             last_step;
      logic             emit;
      logic             emit_last;
      logic [IDX_W-1:0] out_row;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

### rtl/lgs_datapath.sv
// ----------------------------------------------------------------------------
// lgs_datapath
// Cell grid as a rotating row line, next-generation row logic and the
// registered result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgs_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lgs_pkg::ctrl_cmd_type    cmd,
   input  wire logic [lgs_pkg::IDX_W-1:0]  req_row_index,
   input  wire logic [lgs_pkg::MASK_W-1:0] req_row_bits,
   output logic                          rsp_strobe,
   output logic [lgs_pkg::IDX_W-1:0]     rsp_out_row,
   output logic [lgs_pkg::MASK_W-1:0]    rsp_red_mask,
   output logic [lgs_pkg::MASK_W-1:0]    rsp_green_mask,
   output logic                          rsp_last_row
);
   import lgs_pkg::*;

   row_type grid_ff [GRID_ROWS];
   row_type grid_in [GRID_ROWS];
   row_type prev_ff;
   row_type prev_in;

   row_type above;
   row_type cur;
   row_type below;
   row_type new_row;
   row_type load_row;

   logic [GRID_COLS+MASK_BITS-1:0] bits_ext;
   logic [GRID_COLS+MASK_BITS-1:0] red_ext;
   logic [GRID_COLS+MASK_BITS-1:0] green_ext;

   logic              strobe_ff;
   logic [IDX_W-1:0]  out_row_ff;
   logic [MASK_W-1:0] red_ff;
   logic [MASK_W-1:0] green_ff;
   logic              last_ff;

   function automatic row_type next_gen(input row_type a, input row_type m, input row_type b);
      logic [GRID_COLS+1:0] la;
      logic [GRID_COLS+1:0] lm;
      logic [GRID_COLS+1:0] lb;
      logic [NBR_W-1:0]     n;
      row_type              res;
      for (int c = 0; c < GRID_COLS; c++) begin
         la[c+1] = |a[c];
         lm[c+1] = |m[c];
         lb[c+1] = |b[c];
      end
      la[0] = 1'b0;
      lm[0] = 1'b0;
      lb[0] = 1'b0;
      la[GRID_COLS+1] = 1'b0;
      lm[GRID_COLS+1] = 1'b0;
      lb[GRID_COLS+1] = 1'b0;
      for (int c = 0; c < GRID_COLS; c++) begin
         n = NBR_W'(la[c]) + NBR_W'(la[c+1]) + NBR_W'(la[c+2])
           + NBR_W'(lm[c]) + NBR_W'(lm[c+2])
           + NBR_W'(lb[c]) + NBR_W'(lb[c+1]) + NBR_W'(lb[c+2]);
         if (lm[c+1]) begin
            if (n == NBR_KEEP) begin
               res[c] = CELL_SURV2;
            end else if (n == NBR_BIRTH) begin
               res[c] = CELL_SURV3;
            end else begin
               res[c] = CELL_DEAD;
            end
         end else begin
            res[c] = (n == NBR_BIRTH) ? CELL_NEWBORN : CELL_DEAD;
         end
      end
      return res;
   endfunction

   // row window around the row at the head of the line
   always_comb begin
      cur   = grid_ff[0];
      above = cmd.first ? '0 : prev_ff;
      below = cmd.last_step ? '0 : grid_ff[1];
      new_row = cmd.advance ? next_gen(above, cur, below) : cur;
   end

   always_comb begin
      bits_ext = (GRID_COLS+MASK_BITS)'(req_row_bits);
      for (int c = 0; c < GRID_COLS; c++) begin
         load_row[c] = bits_ext[c] ? CELL_NEWBORN : CELL_DEAD;
      end
   end

   always_comb begin
      red_ext   = '0;
      green_ext = '0;
      for (int c = 0; c < GRID_COLS; c++) begin
         red_ext[c]   = new_row[c][1];
         green_ext[c] = new_row[c][0];
      end
   end

   always_comb begin
      prev_in = prev_ff;
      for (int i = 0; i < GRID_ROWS; i++) begin
         grid_in[i] = grid_ff[i];
      end
      if (cmd.sweep) begin
         for (int i = 0; i < GRID_ROWS - 1; i++) begin
            grid_in[i] = grid_ff[i+1];
         end
         grid_in[GRID_ROWS-1] = new_row;
         prev_in = cur;
      end else if (cmd.load_en) begin
         for (int i = 0; i < GRID_ROWS; i++) begin
            if (int'(req_row_index) == i) begin
               grid_in[i] = load_row;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GRID_ROWS; i++) begin
            grid_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < GRID_ROWS; i++) begin
            grid_ff[i] <= grid_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_row_ff <= cmd.out_row;
         red_ff     <= red_ext[MASK_W-1:0];
         green_ff   <= green_ext[MASK_W-1:0];
         last_ff    <= cmd.emit_last;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_red_mask   = red_ff;
   assign rsp_green_mask = green_ff;
   assign rsp_last_row   = last_ff;

endmodule

`default_nettype wire

### rtl/lgs_controller.sv
// ----------------------------------------------------------------------------
// lgs_controller
// Accepts command words and sequences the row sweep of an advance or show.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgs_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire lgs_pkg::op_type        req_op,
   output logic                        busy,
   output lgs_pkg::ctrl_cmd_type       cmd
);
   import lgs_pkg::*;

   state_type        state_ff;
   state_type        state_in;
   logic [ROW_W-1:0] count_ff;
   logic [ROW_W-1:0] count_in;
   logic             adv_ff;
   logic             adv_in;
   logic             accept;
   logic             last_step;

   assign accept    = start && (state_ff == ST_IDLE);
   assign last_step = (count_ff == ROW_W'(GRID_ROWS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op inside {OP_ADVANCE, OP_SHOW})) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (last_step) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in = (state_ff == ST_SWEEP && !last_step) ? count_ff + 1'b1 : '0;
      adv_in   = accept ? (req_op == OP_ADVANCE) : adv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         adv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         adv_ff   <= adv_in;
      end
   end

   // outputs
   always_comb begin
      busy          = 1'b0;
      cmd.load_en   = 1'b0;
      cmd.sweep     = 1'b0;
      cmd.advance   = adv_ff;
      cmd.first     = (count_ff == '0);
      cmd.last_step = last_step;
      cmd.emit      = 1'b0;
      cmd.emit_last = (count_ff == ROW_W'(SHOWN_ROWS - 1));
      cmd.out_row   = IDX_W'(count_ff);
      case (state_ff)
         ST_IDLE: begin
            cmd.load_en = accept && (req_op == OP_LOAD);
         end
         ST_SWEEP: begin
            busy      = 1'b1;
            cmd.sweep = 1'b1;
            cmd.emit  = ({1'b0, count_ff} < (ROW_W+1)'(SHOWN_ROWS));
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && last_step) |=> (state_ff == ST_IDLE))
      else $error("sweep did not end after the last row");

   a_advance_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_ADVANCE) |=> (state_ff == ST_SWEEP && adv_ff && count_ff == '0))
      else $error("advance word did not start a computing sweep");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (state_ff == ST_SWEEP))
      else $error("row counter running outside a sweep");

   a_no_load_in_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> !cmd.load_en)
      else $error("row load during a sweep");
`endif

endmodule

`default_nettype wire

### rtl/life_grid_generation_step_core.sv
// ----------------------------------------------------------------------------
// life_grid_generation_step_core
// Game of life engine on a bounded grid with per-row display masks.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. A load word
// (req_op load) writes one row in the cycle it is taken and leaves busy low,
// so loads can follow each other every cycle. An advance word computes the
// next generation and a show word leaves the grid as is; both then sweep the
// grid one row per cycle, busy high for the whole sweep, so the next advance
// or show word can be taken only once the sweep has ended and busy is low.
// Each row of the first eight gives one result word on the rsp_ ports, marked
// by rsp_strobe for one cycle: the first comes once the state register is in
// the sweep and the result registers have caught the head row; the rest follow
// one per cycle and rsp_last_row flags the last. The sweep rate is set by the
// next-generation logic, which handles one row per cycle while the row line
// rotates. Unused op codes are taken and do nothing. The receiver cannot stall:
// it must take each result word in its cycle. A synchronous reset clears the
// grid to all dead cells and returns the core to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module life_grid_generation_step_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [lgs_pkg::OP_W-1:0]   req_op,
   input  wire logic [lgs_pkg::IDX_W-1:0]  req_row_index,
   input  wire logic [lgs_pkg::MASK_W-1:0] req_row_bits,
   output logic                            rsp_strobe,
   output logic [lgs_pkg::IDX_W-1:0]       rsp_out_row,
   output logic [lgs_pkg::MASK_W-1:0]      rsp_red_mask,
   output logic [lgs_pkg::MASK_W-1:0]      rsp_green_mask,
   output logic                            rsp_last_row
);
   import lgs_pkg::*;

   ctrl_cmd_type cmd;

   lgs_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .busy   (busy),
      .cmd    (cmd)
   );

   lgs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_row_index  (req_row_index),
      .req_row_bits   (req_row_bits),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_row    (rsp_out_row),
      .rsp_red_mask   (rsp_red_mask),
      .rsp_green_mask (rsp_green_mask),
      .rsp_last_row   (rsp_last_row)
   );

endmodule

`default_nettype wire
